### rtl/core/pipt_pkg.sv
// Shared constants and control types for the point-in-polygon test block.
// No dependencies; compiled first.
`default_nettype none

package pipt_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_BITS_DEF   = 24;
   localparam int INDEX_BITS       = 6;
   localparam int COUNT_BITS       = 7;

   // command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // control for the vertex ring
   typedef struct packed {
      logic                  load;
      logic                  shift;
      logic [INDEX_BITS-1:0] index;
   } cell_ctl_type;

   // control for the edge unit
   typedef struct packed {
      logic clear;
      logic issue;
   } edge_ctl_type;

endpackage

`default_nettype wire

### rtl/core/pipt_req_if.sv
// Request channel: valid/ready handshake carrying a load or a query.
// Depends on pipt_pkg.
`default_nettype none

interface pipt_req_if #(
   parameter int COORD_BITS = pipt_pkg::COORD_BITS_DEF
);
   logic                                  valid;
   logic                                  ready;
   logic                                  command;
   logic [pipt_pkg::INDEX_BITS-1:0]       vertex_index;
   logic signed [COORD_BITS-1:0]          coord_x;
   logic signed [COORD_BITS-1:0]          coord_y;

   modport source (output valid, command, vertex_index, coord_x, coord_y, input ready);
   modport sink   (input valid, command, vertex_index, coord_x, coord_y, output ready);
endinterface

`default_nettype wire

### rtl/core/pipt_rsp_if.sv
// Response channel: valid/ready handshake carrying the inside flag.
// No dependencies.
`default_nettype none

interface pipt_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink   (input valid, inside_res, output ready);
endinterface

`default_nettype wire

### rtl/core/pipt_cell.sv
// One vertex cell of the ring: written by a load at its own slot,
// hands its vertex to the previous cell while a query rotates the ring. Uses pipt_pkg.
`default_nettype none

module pipt_cell #(
   parameter int SLOT       = 0,
   parameter int COORD_BITS = pipt_pkg::COORD_BITS_DEF
) (
   input  wire                          clock,
   input  pipt_pkg::cell_ctl_type       ctl,
   input  wire signed [COORD_BITS-1:0]  load_x,
   input  wire signed [COORD_BITS-1:0]  load_y,
   input  wire signed [COORD_BITS-1:0]  next_x,
   input  wire signed [COORD_BITS-1:0]  next_y,
   output logic signed [COORD_BITS-1:0] vx,
   output logic signed [COORD_BITS-1:0] vy
);
   import pipt_pkg::*;

   logic signed [COORD_BITS-1:0] x_ff, y_ff;
   logic                         hit;

   assign hit = ctl.load && (32'(ctl.index) == 32'(SLOT));

   always_ff @(posedge clock) begin
      if (hit) begin
         x_ff <= load_x;
         y_ff <= load_y;
      end else if (ctl.shift) begin
         x_ff <= next_x;
         y_ff <= next_y;
      end
   end

   assign vx = x_ff;
   assign vy = y_ff;

endmodule

`default_nettype wire

### rtl/core/pipt_edge.sv
// Edge crossing unit: straddle test, exact cross-multiplied side test,
// parity accumulate. Three register stages. Uses pipt_pkg.
`default_nettype none

module pipt_edge #(
   parameter int COORD_BITS = pipt_pkg::COORD_BITS_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  pipt_pkg::edge_ctl_type      ctl,
   input  wire signed [COORD_BITS-1:0] xi,
   input  wire signed [COORD_BITS-1:0] yi,
   input  wire signed [COORD_BITS-1:0] xj,
   input  wire signed [COORD_BITS-1:0] yj,
   input  wire signed [COORD_BITS-1:0] px,
   input  wire signed [COORD_BITS-1:0] py,
   output logic                        parity
);
   import pipt_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   logic signed [DW-1:0] a_in, dy_in, c_in, d_in;
   logic signed [DW-1:0] a_ff, dy_ff, c_ff, d_ff;
   logic                 va_in, va_ff;
   logic signed [PW-1:0] p1_ff, p2_ff;
   logic                 neg_ff, vb_ff;
   logic                 left;
   logic                 parity_ff;

   // stage A: differences and straddle
   assign va_in = ctl.issue && ((yi > py) != (yj > py));
   assign dy_in = {yj[COORD_BITS-1], yj} - {yi[COORD_BITS-1], yi};
   assign a_in  = {px[COORD_BITS-1], px} - {xi[COORD_BITS-1], xi};
   assign c_in  = {xj[COORD_BITS-1], xj} - {xi[COORD_BITS-1], xi};
   assign d_in  = {py[COORD_BITS-1], py} - {yi[COORD_BITS-1], yi};

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      dy_ff  <= dy_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      // stage B: the two cross products
      p1_ff  <= a_ff * dy_ff;
      p2_ff  <= c_ff * d_ff;
      neg_ff <= dy_ff[DW-1];
   end

   // stage C: point left of crossing, sign of the span flips the compare
   assign left = neg_ff ? (p1_ff > p2_ff) : (p1_ff < p2_ff);

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         parity_ff <= 1'b0;
      end else if (vb_ff && left) begin
         parity_ff <= ~parity_ff;
      end
   end

   assign parity = parity_ff;

endmodule

`default_nettype wire

### rtl/core/point_in_polygon_test_top.sv
// Top level of the point-in-polygon test: vertex ring, edge unit, sequencer.
// Depends on pipt_pkg, pipt_req_if, pipt_rsp_if, pipt_cell, pipt_edge.
//
// Usage:
//  - req_bus carries one item per transfer. command LOAD writes coord_x/y into
//    slot vertex_index (slots at or above MAX_VERTICES are dropped) and
//    produces no response. command QUERY tests point (x, y).
//  - csr_we/csr_wdata set vertex_count; write it only while idle. Counts above
//    MAX_VERTICES act as MAX_VERTICES; below two every query answers outside.
//  - rsp_bus returns one inside_res per query, even-odd rule.
// Timing:
//  - A query rotates the vertex ring once through all MAX_VERTICES cells, one
//    vertex per cycle into the edge unit, then issues the closing edge and
//    drains the three-stage edge pipeline. The time from transfer to response
//    is independent of vertex_count. The ring rotation sets the rate; one query
//    is in flight at a time.
//  - req_bus.ready is high only in idle; while idle a load is taken every cycle.
//  - The response sits in an output register; a new item is accepted while
//    it waits. A finished query holds until that register frees up.
// Reset: clears control and vertex_count; vertex slots are undefined until
// loaded, and queries must only cover loaded slots.
`default_nettype none

module point_in_polygon_test_top #(
   parameter int MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = pipt_pkg::COORD_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   pipt_req_if.sink                         req_bus,
   pipt_rsp_if.source                       rsp_bus,
   input  wire                              csr_we,
   input  wire [pipt_pkg::COUNT_BITS-1:0]   csr_wdata
);
   import pipt_pkg::*;

   localparam int CW = $clog2(MAX_VERTICES + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   // last DRAIN step index; the parity has settled by the time DONE is entered
   localparam logic [CW-1:0] DRAIN_LAST = CW'(1);
   localparam logic [CW-1:0] STEP_END   = CW'(MAX_VERTICES);

   logic [COUNT_BITS-1:0] count_ff;
   logic [CW-1:0]         n_eff;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] step_ff, step_in;

   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic signed [COORD_BITS-1:0] first_x_ff, first_y_ff;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff;

   logic rsp_valid_ff, rsp_data_ff;

   logic req_xfer, query_start, load_now, rotating, closing, finish;

   cell_ctl_type cell_ctl;
   edge_ctl_type edge_ctl;
   logic         parity;

   logic signed [COORD_BITS-1:0] ring_x [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] ring_y [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] edge_xi, edge_yi;

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (32'(count_ff) > 32'(MAX_VERTICES)) begin
         n_eff = CW'(MAX_VERTICES);
      end else begin
         n_eff = CW'(count_ff);
      end
   end

   // ---- handshake ----
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign query_start   = req_xfer && (req_bus.command == CMD_QUERY);
   assign load_now      = req_xfer && (req_bus.command == CMD_LOAD);

   assign rotating = (state_ff == ST_RUN) && (step_ff != STEP_END);
   assign closing  = (state_ff == ST_RUN) && (step_ff == STEP_END);
   assign finish   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_start) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (closing) begin
               state_in = ST_DRAIN;
               step_in  = '0;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         ST_DRAIN: begin
            if (step_ff == DRAIN_LAST) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         ST_DONE: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (query_start) begin
         px_ff <= req_bus.coord_x;
         py_ff <= req_bus.coord_y;
      end
      // ring head carries vertex 'step' while rotating
      if (rotating && (step_ff == '0)) begin
         first_x_ff <= ring_x[0];
         first_y_ff <= ring_y[0];
      end
      if (rotating && (step_ff < n_eff)) begin
         prev_x_ff <= ring_x[0];
         prev_y_ff <= ring_y[0];
      end
   end

   // ---- vertex ring ----
   assign cell_ctl.load  = load_now;
   assign cell_ctl.shift = rotating;
   assign cell_ctl.index = req_bus.vertex_index;

   for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
      pipt_cell #(
         .SLOT       (k),
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock  (clock),
         .ctl    (cell_ctl),
         .load_x (req_bus.coord_x),
         .load_y (req_bus.coord_y),
         .next_x (ring_x[(k + 1) % MAX_VERTICES]),
         .next_y (ring_y[(k + 1) % MAX_VERTICES]),
         .vx     (ring_x[k]),
         .vy     (ring_y[k])
      );
   end

   // ---- edge unit ----
   // edge (i, i-1) for 1 <= i < n while rotating; closing edge (0, n-1) last
   assign edge_ctl.clear = query_start;
   assign edge_ctl.issue = (rotating && (step_ff != '0) && (step_ff < n_eff))
                           || (closing && (n_eff >= CW'(2)));
   assign edge_xi = closing ? first_x_ff : ring_x[0];
   assign edge_yi = closing ? first_y_ff : ring_y[0];

   pipt_edge #(
      .COORD_BITS (COORD_BITS)
   ) u_edge (
      .clock  (clock),
      .reset  (reset),
      .ctl    (edge_ctl),
      .xi     (edge_xi),
      .yi     (edge_yi),
      .xj     (prev_x_ff),
      .yj     (prev_y_ff),
      .px     (px_ff),
      .py     (py_ff),
      .parity (parity)
   );

   // ---- response register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= parity;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.inside_res = rsp_data_ff;

endmodule

`default_nettype wire
